// ----- rtl/core/pfe_pkg.sv -----
package pfe_pkg;

   localparam int FIELD_W = 29;
   localparam int VARINT_W = 32;
   localparam logic [FIELD_W-1:0] TARGET_FIELD_RESET = 29'd101;
   localparam logic [2:0] VARINT_LAST_BYTE = 3'd4;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   typedef enum logic [2:0] {
      PH_KEY = 3'd0,
      PH_VAL = 3'd1,
      PH_LEN = 3'd2,
      PH_FIXED = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_HALT = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_TRUNC = 3'd1,
      ST_LONG = 3'd2,
      ST_WIRE = 3'd3,
      ST_OVERRUN = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic msg_start;
      logic [15:0] msg_length;
   } req_item_type;

   typedef struct packed {
      logic payload_valid;
      logic [7:0] payload_byte;
      logic payload_last;
      logic msg_done;
      logic [2:0] scan_status;
   } rsp_item_type;

   // bit offset of the next 7-bit varint group
   function automatic logic [4:0] varint_shift(input logic [2:0] count);
      logic [4:0] sh;
      unique case (count)
         3'd0: sh = 5'd0;
         3'd1: sh = 5'd7;
         3'd2: sh = 5'd14;
         3'd3: sh = 5'd21;
         3'd4: sh = 5'd28;
         default: sh = 5'd0;
      endcase
      return sh;
   endfunction

endpackage

// ----- rtl/core/pfe_chan_if.sv -----
interface pfe_chan_if #(parameter type data_type = logic);
   logic valid;
   logic ready;
   data_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/pfe_in_stage.sv -----
module pfe_in_stage (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input pfe_pkg::req_item_type in_data,
   output logic in_ready,
   input logic step,
   output logic item_valid,
   output pfe_pkg::req_item_type item
);
   import pfe_pkg::*;

   logic valid_ff;
   req_item_type data_ff;

   assign in_ready = !valid_ff || step;
   assign item_valid = valid_ff;
   assign item = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (step) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end
endmodule

// ----- rtl/core/pfe_parser.sv -----
module pfe_parser #(
   parameter int LENGTH_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [pfe_pkg::FIELD_W-1:0] csr_wr_data,
   input logic item_valid,
   input pfe_pkg::req_item_type item,
   input logic step,
   output logic has_result,
   output pfe_pkg::rsp_item_type result
);
   import pfe_pkg::*;

   logic [FIELD_W-1:0] target_ff;
   phase_type phase_ff, phase_in, phase_e;
   logic [VARINT_W-1:0] acc_ff, acc_in, acc_e, acc_new;
   logic [2:0] cnt_ff, cnt_in, cnt_e, cnt_new;
   logic match_ff, match_in, match_e;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in, rem_e, rem_after, len;
   logic [LENGTH_BITS-1:0] skip_ff, skip_in, skip_e, need;
   status_type halt_ff, halt_in, halt_e, st;
   logic active, v_done, v_long, done, pv, pl;
   logic [7:0] pb;

   always_comb begin
      len = LENGTH_BITS'(item.msg_length);
      if (len == '0) begin
         len = LENGTH_BITS'(1);
      end
      active = item_valid && (item.msg_start || rem_ff != '0);

      phase_e = item.msg_start ? PH_KEY : phase_ff;
      acc_e = item.msg_start ? '0 : acc_ff;
      cnt_e = item.msg_start ? 3'd0 : cnt_ff;
      match_e = item.msg_start ? 1'b0 : match_ff;
      skip_e = item.msg_start ? '0 : skip_ff;
      halt_e = item.msg_start ? ST_OK : halt_ff;
      rem_e = item.msg_start ? len : rem_ff;
      rem_after = rem_e - LENGTH_BITS'(1);

      acc_new = acc_e | (VARINT_W'(item.byte_in[6:0]) << varint_shift(cnt_e));
      cnt_new = cnt_e + 3'd1;
      v_done = !item.byte_in[7];
      v_long = item.byte_in[7] && (cnt_e == VARINT_LAST_BYTE);
      need = (acc_new[2:0] == WT_FIXED64) ? LENGTH_BITS'(8) : LENGTH_BITS'(4);

      phase_in = phase_e;
      acc_in = acc_e;
      cnt_in = cnt_e;
      match_in = match_e;
      skip_in = skip_e;
      halt_in = halt_e;
      pv = 1'b0;
      pb = 8'd0;
      pl = 1'b0;

      unique case (phase_e)
         PH_KEY: begin
            acc_in = acc_new;
            cnt_in = cnt_new;
            if (v_long) begin
               phase_in = PH_HALT;
               halt_in = ST_LONG;
            end else if (v_done) begin
               acc_in = '0;
               cnt_in = 3'd0;
               unique case (acc_new[2:0])
                  WT_VARINT: begin
                     phase_in = PH_VAL;
                  end
                  WT_FIXED64, WT_FIXED32: begin
                     if (rem_after < need) begin
                        phase_in = PH_HALT;
                        halt_in = ST_TRUNC;
                     end else begin
                        skip_in = need;
                        phase_in = PH_FIXED;
                     end
                  end
                  WT_LEN: begin
                     match_in = (acc_new[VARINT_W-1:3] == target_ff);
                     phase_in = PH_LEN;
                  end
                  default: begin
                     phase_in = PH_HALT;
                     halt_in = ST_WIRE;
                  end
               endcase
            end
         end
         PH_VAL: begin
            acc_in = acc_new;
            cnt_in = cnt_new;
            if (v_long) begin
               phase_in = PH_HALT;
               halt_in = ST_LONG;
            end else if (v_done) begin
               acc_in = '0;
               cnt_in = 3'd0;
               phase_in = PH_KEY;
            end
         end
         PH_LEN: begin
            acc_in = acc_new;
            cnt_in = cnt_new;
            if (v_long) begin
               phase_in = PH_HALT;
               halt_in = ST_LONG;
            end else if (v_done) begin
               acc_in = '0;
               cnt_in = 3'd0;
               if (acc_new > VARINT_W'(rem_after)) begin
                  phase_in = PH_HALT;
                  halt_in = ST_OVERRUN;
               end else if (acc_new == '0) begin
                  phase_in = PH_KEY;
               end else begin
                  skip_in = LENGTH_BITS'(acc_new);
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_FIXED: begin
            skip_in = skip_e - LENGTH_BITS'(1);
            if (skip_in == '0) begin
               phase_in = PH_KEY;
            end
         end
         PH_PAYLOAD: begin
            if (match_e) begin
               pv = 1'b1;
               pb = item.byte_in;
               pl = (skip_e == LENGTH_BITS'(1));
            end
            skip_in = skip_e - LENGTH_BITS'(1);
            if (skip_in == '0) begin
               phase_in = PH_KEY;
            end
         end
         PH_HALT: begin
         end
         default: begin
         end
      endcase

      done = (rem_after == '0);
      st = ST_OK;
      if (done) begin
         if (phase_in == PH_HALT) begin
            st = halt_in;
         end else if (phase_in == PH_KEY && cnt_in == 3'd0) begin
            st = ST_OK;
         end else begin
            st = ST_TRUNC;
         end
         phase_in = PH_KEY;
         acc_in = '0;
         cnt_in = 3'd0;
         match_in = 1'b0;
         skip_in = '0;
         halt_in = ST_OK;
      end
      rem_in = rem_after;

      has_result = active && (pv || done);
      result.payload_valid = pv;
      result.payload_byte = pb;
      result.payload_last = pl;
      result.msg_done = done;
      result.scan_status = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_FIELD_RESET;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY;
         acc_ff <= '0;
         cnt_ff <= 3'd0;
         match_ff <= 1'b0;
         rem_ff <= '0;
         skip_ff <= '0;
         halt_ff <= ST_OK;
      end else if (step && active) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         match_ff <= match_in;
         rem_ff <= rem_in;
         skip_ff <= skip_in;
         halt_ff <= halt_in;
      end
   end
endmodule

// ----- rtl/core/pfe_out_stage.sv -----
module pfe_out_stage (
   input logic clock,
   input logic reset,
   input logic load,
   input pfe_pkg::rsp_item_type load_data,
   output logic out_valid,
   input logic out_ready,
   output pfe_pkg::rsp_item_type out_data
);
   import pfe_pkg::*;

   logic valid_ff;
   rsp_item_type data_ff;

   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end
endmodule

// ----- rtl/core/protobuf_field_extractor_top.sv -----
// Protobuf wire-format scanner, one message byte per req beat. A beat with msg_start set
// opens a message of msg_length bytes (0 counts as 1) and abandons any message in flight;
// beats outside a message are dropped. Keys, varints (5 bytes max), fixed64/fixed32 and
// length-delimited fields are walked; only the payload bytes of the length-delimited field
// numbered csr_wr_data (reset 101) come out as rsp beats with payload_last on the final one.
// The final byte of a message gives a beat with msg_done and scan_status (0 clean,
// 1 truncated, 2 varint too long, 3 bad wire type, 4 length overrun); after an error the
// rest of the message is swallowed. Throughput is one byte per clock while rsp backpressure
// does not hold the rsp register: an input register, a single pass of parser logic and an
// output register that drives rsp valid. A byte that makes a beat waits in the input
// register while the rsp register is held by rsp backpressure. Write the target field only
// while no message is in flight.
module protobuf_field_extractor_top #(
   parameter int LENGTH_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [pfe_pkg::FIELD_W-1:0] csr_wr_data,
   pfe_chan_if.sink req_bus,
   pfe_chan_if.source rsp_bus
);
   import pfe_pkg::*;

   logic item_valid, step, has_result, out_valid;
   req_item_type item;
   rsp_item_type result, out_data;

   assign step = item_valid && (!has_result || !out_valid || rsp_bus.ready);
   assign rsp_bus.valid = out_valid;
   assign rsp_bus.data = out_data;

   pfe_in_stage u_in (
      .clock(clock),
      .reset(reset),
      .in_valid(req_bus.valid),
      .in_data(req_bus.data),
      .in_ready(req_bus.ready),
      .step(step),
      .item_valid(item_valid),
      .item(item)
   );

   pfe_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .item_valid(item_valid),
      .item(item),
      .step(step),
      .has_result(has_result),
      .result(result)
   );

   pfe_out_stage u_out (
      .clock(clock),
      .reset(reset),
      .load(step && has_result),
      .load_data(result),
      .out_valid(out_valid),
      .out_ready(rsp_bus.ready),
      .out_data(out_data)
   );
endmodule

// ----- rtl/core/pfe_checker.sv -----
module pfe_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input pfe_pkg::rsp_item_type rsp_data
);
   import pfe_pkg::*;

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // every beat carries a payload byte or an end of message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.payload_valid || rsp_data.msg_done)
      else $error("empty rsp beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.payload_valid |->
         rsp_data.payload_byte == 8'd0 && !rsp_data.payload_last)
      else $error("payload fields set without payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.msg_done |-> rsp_data.scan_status == ST_OK)
      else $error("status set without end of message");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind protobuf_field_extractor_top pfe_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_data(rsp_bus.data)
);
